@@ rtl/dsbmf_pkg.sv @@
// Package for the dual sensor ball motion fuser: constants, register codes,
// controller states and the command and status bundles between controller and datapath.
// No dependencies.
`default_nettype none

package dsbmf_pkg;

  localparam int unsigned FRACTION_BITS_DEF = 14;
  localparam int unsigned MOTION_WIDTH_DEF  = 16;
  localparam int unsigned GAIN_FRACTION     = 14;
  localparam int unsigned GAIN_WIDTH        = 16;
  localparam int unsigned TICK_WIDTH        = 8;
  localparam int unsigned MOVE_WIDTH        = 8;
  localparam int unsigned BUTTON_WIDTH      = 3;
  localparam int unsigned CFG_INDEX_WIDTH   = 8;
  localparam int unsigned CFG_DATA_WIDTH    = 16;

  localparam logic [TICK_WIDTH-1:0] SCROLL_TICK_RESET = 8'd64;
  localparam logic [GAIN_WIDTH-1:0] GAIN_RESET        = 16'd23170;

  localparam logic signed [MOVE_WIDTH-1:0] MOVE_MAX = 8'sh7f;
  localparam logic signed [MOVE_WIDTH-1:0] MOVE_MIN = 8'sh80;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_INVERT_FIRST  = 8'd0,
    REG_INVERT_SECOND = 8'd1,
    REG_SCROLL_TICK   = 8'd2,
    REG_OFF_AXIS_GAIN = 8'd3
  } dsbmf_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_AXES,
    ST_MAG,
    ST_CHECK,
    ST_SPLIT,
    ST_DIV,
    ST_FIN
  } dsbmf_state_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic axes;
    logic mag;
    logic check;
    logic split;
    logic div_step;
    logic finish;
  } dsbmf_cmd_t;

  typedef struct packed {
    logic scroll;
    logic div_done;
  } dsbmf_stat_t;

endpackage

`default_nettype wire

@@ rtl/dsbmf_if.sv @@
// Channel interfaces of the motion fuser: motion input, report output and
// configuration write. Depends on dsbmf_pkg.
`default_nettype none

interface dsbmf_motion_if #(
  parameter int unsigned MOTION_WIDTH = dsbmf_pkg::MOTION_WIDTH_DEF
);
  logic                                   valid;
  logic                                   ready;
  logic signed [MOTION_WIDTH-1:0]         first_dx;
  logic signed [MOTION_WIDTH-1:0]         first_dy;
  logic signed [MOTION_WIDTH-1:0]         second_dx;
  logic signed [MOTION_WIDTH-1:0]         second_dy;
  logic [dsbmf_pkg::BUTTON_WIDTH-1:0]     buttons_pressed;

  modport source (
    output valid, first_dx, first_dy, second_dx, second_dy, buttons_pressed,
    input  ready
  );
  modport sink (
    input  valid, first_dx, first_dy, second_dx, second_dy, buttons_pressed,
    output ready
  );
endinterface

interface dsbmf_report_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   report_valid;
  logic                                   wake_request;
  logic [dsbmf_pkg::BUTTON_WIDTH-1:0]     button_mask;
  logic signed [dsbmf_pkg::MOVE_WIDTH-1:0] move_x;
  logic signed [dsbmf_pkg::MOVE_WIDTH-1:0] move_y;
  logic signed [dsbmf_pkg::MOVE_WIDTH-1:0] wheel;
  logic                                   click;

  modport source (
    output valid, report_valid, wake_request, button_mask, move_x, move_y, wheel, click,
    input  ready
  );
  modport sink (
    input  valid, report_valid, wake_request, button_mask, move_x, move_y, wheel, click,
    output ready
  );
endinterface

interface dsbmf_cfg_if;
  logic                                    valid;
  logic                                    ready;
  logic [dsbmf_pkg::CFG_INDEX_WIDTH-1:0]   index;
  logic [dsbmf_pkg::CFG_DATA_WIDTH-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/dual_sensor_ball_motion_fuser_core.sv @@
// Top level of the dual sensor ball motion fuser: joins controller, datapath
// and the channel interfaces. Depends on dsbmf_pkg, dsbmf_if, dsbmf_ctrl and dsbmf_datapath.
//
// One poll transaction on in_ch yields exactly one report transaction on out_ch. Polls are
// processed one at a time: a poll that is not a scroll poll runs through the states MUL, AXES,
// MAG, CHECK, SPLIT and FIN, and a scroll poll also runs through DIV, the bit-serial wheel step
// divider, which produces one quotient bit per cycle. The next poll is accepted in the cycle
// after the report is registered, even while that report still waits on out_ch. Configuration
// writes on cfg_ch are always accepted and unknown register indexes are ignored; write them only
// while no poll is in flight.
`default_nettype none

module dual_sensor_ball_motion_fuser_core #(
  parameter int unsigned FRACTION_BITS = dsbmf_pkg::FRACTION_BITS_DEF,
  parameter int unsigned MOTION_WIDTH  = dsbmf_pkg::MOTION_WIDTH_DEF
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  dsbmf_motion_if.sink     in_ch,
  dsbmf_report_if.source   out_ch,
  dsbmf_cfg_if.sink        cfg_ch
);
  import dsbmf_pkg::*;

  dsbmf_cmd_t  cmd;
  dsbmf_stat_t stat;
  logic        in_ready;
  logic        out_valid;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid;

  dsbmf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_ch.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_ch.ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  dsbmf_datapath #(
    .FRACTION_BITS (FRACTION_BITS),
    .MOTION_WIDTH  (MOTION_WIDTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .cfg_we_i          (cfg_ch.valid),
    .cfg_index_i       (cfg_ch.index),
    .cfg_data_i        (cfg_ch.data),
    .first_dx_i        (in_ch.first_dx),
    .first_dy_i        (in_ch.first_dy),
    .second_dx_i       (in_ch.second_dx),
    .second_dy_i       (in_ch.second_dy),
    .buttons_pressed_i (in_ch.buttons_pressed),
    .report_valid_o    (out_ch.report_valid),
    .wake_request_o    (out_ch.wake_request),
    .button_mask_o     (out_ch.button_mask),
    .move_x_o          (out_ch.move_x),
    .move_y_o          (out_ch.move_y),
    .wheel_o           (out_ch.wheel),
    .click_o           (out_ch.click)
  );

endmodule

`default_nettype wire

@@ rtl/dsbmf_ctrl.sv @@
// Controller of the motion fuser: sequences the datapath steps of one poll
// and owns the input ready and output valid. Depends on dsbmf_pkg.
`default_nettype none

module dsbmf_ctrl (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output dsbmf_pkg::dsbmf_cmd_t    cmd_o,
  input  dsbmf_pkg::dsbmf_stat_t   stat_i
);
  import dsbmf_pkg::*;

  dsbmf_state_e state_q, state_d;
  logic         out_valid_q, out_valid_d;
  logic         out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_MUL;
      ST_MUL:   state_d = ST_AXES;
      ST_AXES:  state_d = ST_MAG;
      ST_MAG:   state_d = ST_CHECK;
      ST_CHECK: state_d = ST_SPLIT;
      ST_SPLIT: state_d = stat_i.scroll ? ST_DIV : ST_FIN;
      ST_DIV:   if (stat_i.div_done) state_d = ST_FIN;
      ST_FIN:   if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MUL:   cmd_o.mul = 1'b1;
      ST_AXES:  cmd_o.axes = 1'b1;
      ST_MAG:   cmd_o.mag = 1'b1;
      ST_CHECK: cmd_o.check = 1'b1;
      ST_SPLIT: cmd_o.split = 1'b1;
      ST_DIV:   cmd_o.div_step = !stat_i.div_done;
      ST_FIN:   cmd_o.finish = out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/dsbmf_datapath.sv @@
// Datapath of the motion fuser: configuration registers, axis arithmetic,
// scroll remainder with a bit-serial step divider, and the result register.
// Depends on dsbmf_pkg.
`default_nettype none

module dsbmf_datapath #(
  parameter int unsigned FRACTION_BITS = dsbmf_pkg::FRACTION_BITS_DEF,
  parameter int unsigned MOTION_WIDTH  = dsbmf_pkg::MOTION_WIDTH_DEF
) (
  input  wire                                       clk_i,
  input  wire                                       rst_ni,
  input  dsbmf_pkg::dsbmf_cmd_t                     cmd_i,
  output dsbmf_pkg::dsbmf_stat_t                    stat_o,
  input  wire                                       cfg_we_i,
  input  wire [dsbmf_pkg::CFG_INDEX_WIDTH-1:0]      cfg_index_i,
  input  wire [dsbmf_pkg::CFG_DATA_WIDTH-1:0]       cfg_data_i,
  input  wire signed [MOTION_WIDTH-1:0]             first_dx_i,
  input  wire signed [MOTION_WIDTH-1:0]             first_dy_i,
  input  wire signed [MOTION_WIDTH-1:0]             second_dx_i,
  input  wire signed [MOTION_WIDTH-1:0]             second_dy_i,
  input  wire [dsbmf_pkg::BUTTON_WIDTH-1:0]         buttons_pressed_i,
  output logic                                      report_valid_o,
  output logic                                      wake_request_o,
  output logic [dsbmf_pkg::BUTTON_WIDTH-1:0]        button_mask_o,
  output logic signed [dsbmf_pkg::MOVE_WIDTH-1:0]   move_x_o,
  output logic signed [dsbmf_pkg::MOVE_WIDTH-1:0]   move_y_o,
  output logic signed [dsbmf_pkg::MOVE_WIDTH-1:0]   wheel_o,
  output logic                                      click_o
);
  import dsbmf_pkg::*;

  localparam int unsigned NW   = MOTION_WIDTH + 1;
  localparam int unsigned PW   = NW + GAIN_WIDTH + 1;
  localparam int unsigned GSH  = (FRACTION_BITS >= GAIN_FRACTION) ?
                                 FRACTION_BITS - GAIN_FRACTION : 0;
  localparam int unsigned GDIV = (FRACTION_BITS < GAIN_FRACTION) ?
                                 GAIN_FRACTION - FRACTION_BITS : 0;
  localparam int unsigned GW   = PW + GSH;
  localparam int unsigned AW   = NW + FRACTION_BITS;
  localparam int unsigned XW   = ((AW > GW) ? AW : GW) + 1;
  localparam int unsigned ZW   = NW + FRACTION_BITS + 1;
  localparam int unsigned CW   = ((XW > ZW) ? XW : ZW) + 1;
  localparam int unsigned RW   = MOTION_WIDTH + FRACTION_BITS + 4;
  localparam int unsigned QW   = RW - FRACTION_BITS;
  localparam int unsigned KW   = $clog2(QW + 1);
  localparam int unsigned LW   = TICK_WIDTH + FRACTION_BITS;

  function automatic logic signed [MOVE_WIDTH-1:0] sat_move(
    input logic                  neg,
    input logic                  ovf,
    input logic [MOVE_WIDTH-1:0] low
  );
    logic signed [MOVE_WIDTH-1:0] res;
    if (!neg) begin
      res = (ovf || low[MOVE_WIDTH-1]) ? MOVE_MAX : signed'(low);
    end else begin
      res = (ovf || (low > unsigned'(MOVE_MIN))) ? MOVE_MIN : signed'(~low + 1'b1);
    end
    return res;
  endfunction

  // Configuration registers.
  logic                  inv_first_q, inv_second_q;
  logic [TICK_WIDTH-1:0] tick_q;
  logic [GAIN_WIDTH-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_first_q  <= 1'b0;
      inv_second_q <= 1'b0;
      tick_q       <= SCROLL_TICK_RESET;
      gain_q       <= GAIN_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_INVERT_FIRST:  inv_first_q  <= cfg_data_i[0];
        REG_INVERT_SECOND: inv_second_q <= cfg_data_i[0];
        REG_SCROLL_TICK:   tick_q       <= cfg_data_i[TICK_WIDTH-1:0];
        REG_OFF_AXIS_GAIN: gain_q       <= cfg_data_i[GAIN_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  // Operand capture and axis arithmetic.
  logic signed [NW-1:0]      ax_q, ay_q, bx_q, by_q;
  logic [BUTTON_WIDTH-1:0]   pressed_q;
  logic signed [GAIN_WIDTH:0] gain_s;
  logic signed [PW-1:0]      prod_q;
  logic signed [PW-1:0]      gain_bias, gain_div;
  logic signed [GW-1:0]      gain_fx;
  logic signed [AW-1:0]      ax_fx;
  logic signed [NW:0]        ab_sum;
  logic signed [XW-1:0]      x_d, x_q;
  logic signed [AW-1:0]      y_q;
  logic signed [ZW-1:0]      z_d, z_q;
  logic [XW-1:0]             mx_q;
  logic [AW-1:0]             my_q;
  logic [ZW-1:0]             mz_q;
  logic                      scroll_q;
  logic signed [RW-1:0]      rem_q, sum_q;
  logic [RW-1:0]             sum_mag;

  assign gain_s    = signed'({1'b0, gain_q});
  assign gain_bias = prod_q[PW-1] ? PW'((1 << GDIV) - 1) : '0;
  assign gain_div  = (prod_q + gain_bias) >>> GDIV;
  assign gain_fx   = GW'(gain_div) <<< GSH;
  assign ax_fx     = AW'(ax_q) <<< FRACTION_BITS;
  assign x_d       = -XW'(ax_fx) - XW'(gain_fx);
  assign ab_sum    = (NW + 1)'(ay_q) + (NW + 1)'(by_q);
  assign z_d       = -(ZW'(ab_sum) <<< (FRACTION_BITS - 1));
  assign sum_mag   = sum_q[RW-1] ? RW'(-sum_q) : RW'(sum_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q      <= inv_first_q  ? -NW'(first_dx_i)  : NW'(first_dx_i);
      ay_q      <= inv_first_q  ? -NW'(first_dy_i)  : NW'(first_dy_i);
      bx_q      <= inv_second_q ? -NW'(second_dx_i) : NW'(second_dx_i);
      by_q      <= inv_second_q ? -NW'(second_dy_i) : NW'(second_dy_i);
      pressed_q <= buttons_pressed_i;
    end
    if (cmd_i.mul) begin
      prod_q <= PW'(gain_s) * PW'(bx_q);
    end
    if (cmd_i.axes) begin
      x_q <= x_d;
      y_q <= ax_fx;
      z_q <= z_d;
    end
    if (cmd_i.mag) begin
      mx_q <= x_q[XW-1] ? XW'(-x_q) : XW'(x_q);
      my_q <= y_q[AW-1] ? AW'(-y_q) : AW'(y_q);
      mz_q <= z_q[ZW-1] ? ZW'(-z_q) : ZW'(z_q);
    end
    if (cmd_i.check) begin
      scroll_q <= (CW'(mz_q) > (CW'(mx_q) << 1)) && (CW'(mz_q) > (CW'(my_q) << 1));
      sum_q    <= rem_q + RW'(z_q);
    end
  end

  // Bit-serial divider: high part of the remainder magnitude by the scroll tick.
  logic [QW-1:0]             div_h_q;
  logic [FRACTION_BITS-1:0]  div_lo_q;
  logic [TICK_WIDTH-1:0]     div_p_q, div_d_q;
  logic [KW-1:0]             div_cnt_q;
  logic                      sum_neg_q;
  logic [TICK_WIDTH:0]       div_t, div_diff;
  logic                      div_ge;

  assign div_t    = {div_p_q, div_h_q[QW-1]};
  assign div_diff = div_t - {1'b0, div_d_q};
  assign div_ge   = div_t >= {1'b0, div_d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
      div_p_q   <= '0;
      div_d_q   <= TICK_WIDTH'(1);
    end else if (cmd_i.split) begin
      div_cnt_q <= KW'(QW);
      div_p_q   <= '0;
      div_d_q   <= (tick_q == '0) ? TICK_WIDTH'(1) : tick_q;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q - 1'b1;
      div_p_q   <= div_ge ? div_diff[TICK_WIDTH-1:0] : div_t[TICK_WIDTH-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.split) begin
      div_h_q   <= sum_mag[RW-1:FRACTION_BITS];
      div_lo_q  <= sum_mag[FRACTION_BITS-1:0];
      sum_neg_q <= sum_q[RW-1];
    end else if (cmd_i.div_step) begin
      div_h_q <= {div_h_q[QW-2:0], div_ge};
    end
  end

  assign stat_o.scroll   = scroll_q;
  assign stat_o.div_done = (div_cnt_q == '0);

  // Result formation, remainder and button state update.
  logic [BUTTON_WIDTH-1:0]        held_q;
  logic [LW-1:0]                  rem_mag;
  logic signed [RW-1:0]           rem_new;
  logic [XW-1:0]                  xt;
  logic [AW-1:0]                  yt;
  logic                           changed, steps_nz;
  logic                           report_q, wake_q, click_q;
  logic [BUTTON_WIDTH-1:0]        mask_q;
  logic signed [MOVE_WIDTH-1:0]   move_x_q, move_y_q, wheel_q;
  logic [RW-1:0]                  rem_abs;

  assign rem_mag  = {div_p_q, div_lo_q};
  assign rem_new  = sum_neg_q ? -RW'(rem_mag) : RW'(rem_mag);
  assign xt       = mx_q >> FRACTION_BITS;
  assign yt       = my_q >> FRACTION_BITS;
  assign changed  = (pressed_q != held_q);
  assign steps_nz = |div_h_q;
  assign rem_abs  = rem_q[RW-1] ? RW'(-rem_q) : RW'(rem_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      rem_q  <= '0;
    end else if (cmd_i.finish) begin
      held_q <= pressed_q;
      if (scroll_q) begin
        rem_q <= rem_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      wake_q <= changed;
      mask_q <= pressed_q;
      if (scroll_q) begin
        report_q <= changed || steps_nz;
        move_x_q <= '0;
        move_y_q <= '0;
        wheel_q  <= sat_move(sum_neg_q, |div_h_q[QW-1:MOVE_WIDTH],
                             div_h_q[MOVE_WIDTH-1:0]);
        click_q  <= steps_nz;
      end else begin
        report_q <= changed || (x_q != '0) || (y_q != '0);
        move_x_q <= sat_move(x_q[XW-1], |xt[XW-1:MOVE_WIDTH], xt[MOVE_WIDTH-1:0]);
        move_y_q <= sat_move(y_q[AW-1], |yt[AW-1:MOVE_WIDTH], yt[MOVE_WIDTH-1:0]);
        wheel_q  <= '0;
        click_q  <= 1'b0;
      end
    end
  end

  assign report_valid_o = report_q;
  assign wake_request_o = wake_q;
  assign button_mask_o  = mask_q;
  assign move_x_o       = move_x_q;
  assign move_y_o       = move_y_q;
  assign wheel_o        = wheel_q;
  assign click_o        = click_q;

  a_div_partial_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_p_q < div_d_q)
    else $error("Divider partial remainder reached the divisor.");

  a_remainder_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && scroll_q |=> rem_abs < (RW'(div_d_q) << FRACTION_BITS))
    else $error("Scroll remainder not below one wheel step after a scroll poll.");

  a_scroll_zeroes_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && scroll_q |=> move_x_q == '0 && move_y_q == '0)
    else $error("Pointer moves are nonzero on a scroll poll.");

  a_click_tracks_wheel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish |=> click_q == (wheel_q != '0))
    else $error("Click flag disagrees with the wheel count.");

endmodule

`default_nettype wire

@@ tb/dual_sensor_ball_motion_fuser_core_tb.sv @@
// Self-checking testbench for dual_sensor_ball_motion_fuser_core. A queue-fed driver offers
// poll transactions, and a monitor checks every report against an in-bench fusion predictor.
// Depends on dsbmf_pkg, dsbmf_if and the core RTL.
module dual_sensor_ball_motion_fuser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import dsbmf_pkg::*;

  localparam int unsigned FB = FRACTION_BITS_DEF;
  localparam int unsigned MW = MOTION_WIDTH_DEF;
  localparam longint ONE = longint'(1) << FB;
  localparam int SCROLL_LATENCY = 7 + MW + 4;
  localparam int DRAIN_CYCLES = SCROLL_LATENCY + 10;
  localparam int RECEIVER_HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int POLLS_PER_PHASE = 131;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_INDEX_UNUSED_MIN = 8'd4;

  typedef struct {
    logic signed [MW-1:0]    first_dx;
    logic signed [MW-1:0]    first_dy;
    logic signed [MW-1:0]    second_dx;
    logic signed [MW-1:0]    second_dy;
    logic [BUTTON_WIDTH-1:0] buttons;
  } poll_t;

  typedef struct {
    logic                          report_valid;
    logic                          wake_request;
    logic [BUTTON_WIDTH-1:0]       button_mask;
    logic signed [MOVE_WIDTH-1:0]  move_x;
    logic signed [MOVE_WIDTH-1:0]  move_y;
    logic signed [MOVE_WIDTH-1:0]  wheel;
    logic                          click;
  } fused_report_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  dsbmf_motion_if #(.MOTION_WIDTH(MW)) in_ch ();
  dsbmf_report_if out_ch ();
  dsbmf_cfg_if cfg_ch ();

  dual_sensor_ball_motion_fuser_core #(
    .FRACTION_BITS(FB),
    .MOTION_WIDTH (MW)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  logic                    cfg_invert_first = 1'b0;
  logic                    cfg_invert_second = 1'b0;
  logic [TICK_WIDTH-1:0]   cfg_scroll_tick = SCROLL_TICK_RESET;
  logic [GAIN_WIDTH-1:0]   cfg_gain = GAIN_RESET;
  logic [BUTTON_WIDTH-1:0] held_model = '0;
  longint                  scroll_rem_model = 0;

  poll_t                   poll_queue[$];
  fused_report_t           pending_reports[$];
  logic [BUTTON_WIDTH-1:0] last_buttons = '0;
  int                      sender_idle_pct = 0;
  int                      sink_stall_pct = 0;
  bit                      sink_hold = 1'b0;
  int                      error_count = 0;
  int                      reports_seen = 0;
  int                      quiet_cycles = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic longint magnitude_of(longint v);
    return (v < 0) ? -v : v;
  endfunction

  function automatic logic signed [MOVE_WIDTH-1:0] saturate_move(longint v);
    if (v > longint'(MOVE_MAX)) return MOVE_MAX;
    if (v < longint'(MOVE_MIN)) return MOVE_MIN;
    return v[MOVE_WIDTH-1:0];
  endfunction

  function automatic fused_report_t fuse_motion(poll_t p);
    longint        ax, ay, bx, by, gain_term, x, y, z, tick_fx, steps;
    logic          changed;
    fused_report_t r;
    ax = p.first_dx;
    ay = p.first_dy;
    bx = p.second_dx;
    by = p.second_dy;
    if (cfg_invert_first) begin
      ax = -ax;
      ay = -ay;
    end
    if (cfg_invert_second) begin
      bx = -bx;
      by = -by;
    end
    gain_term = longint'(cfg_gain) * bx;
    if (FB >= GAIN_FRACTION) begin
      gain_term = gain_term * (longint'(1) << (FB - GAIN_FRACTION));
    end else begin
      gain_term = gain_term / (longint'(1) << (GAIN_FRACTION - FB));
    end
    x = -(ax * ONE) - gain_term;
    y = ax * ONE;
    z = -(ay + by) * (ONE / 2);
    steps = 0;
    if (magnitude_of(z) > 2 * magnitude_of(x) && magnitude_of(z) > 2 * magnitude_of(y)) begin
      tick_fx = ((cfg_scroll_tick == '0) ? longint'(1) : longint'(cfg_scroll_tick)) * ONE;
      scroll_rem_model += z;
      steps = scroll_rem_model / tick_fx;
      scroll_rem_model -= steps * tick_fx;
      x = 0;
      y = 0;
    end
    changed = (p.buttons != held_model);
    held_model = p.buttons;
    r.report_valid = changed || x != 0 || y != 0 || steps != 0;
    r.wake_request = changed;
    r.button_mask  = held_model;
    r.move_x       = saturate_move(x / ONE);
    r.move_y       = saturate_move(y / ONE);
    r.wheel        = saturate_move(steps);
    r.click        = (steps != 0);
    return r;
  endfunction

  function automatic int signed_within(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // About 45 in 100 polls are shaped to reach the scroll path, where the remainder carries state.
  function automatic poll_t random_poll();
    poll_t p;
    int    kind;
    int    span;
    kind = $urandom_range(99);
    if (kind < 45) begin
      case ($urandom_range(3))
        0: span = 3;
        1: span = 60;
        2: span = 700;
        default: span = 32767;
      endcase
      p.first_dx  = MW'(($urandom_range(3) == 0) ? signed_within(2) : 0);
      p.second_dx = MW'(($urandom_range(3) == 0) ? signed_within(2) : 0);
      p.first_dy  = MW'(signed_within(span));
      p.second_dy = MW'(signed_within(span));
    end else if (kind < 80) begin
      case ($urandom_range(2))
        0: span = 2;
        1: span = 40;
        default: span = 400;
      endcase
      p.first_dx  = MW'(signed_within(span));
      p.first_dy  = MW'(signed_within(span));
      p.second_dx = MW'(signed_within(span));
      p.second_dy = MW'(signed_within(span));
    end else if (kind < 92) begin
      p.first_dx  = MW'($urandom());
      p.first_dy  = MW'($urandom());
      p.second_dx = MW'($urandom());
      p.second_dy = MW'($urandom());
    end else begin
      p.first_dx  = '0;
      p.first_dy  = '0;
      p.second_dx = '0;
      p.second_dy = '0;
    end
    if ($urandom_range(9) >= 7) begin
      last_buttons = BUTTON_WIDTH'($urandom());
    end
    p.buttons = last_buttons;
    return p;
  endfunction

  task automatic queue_poll(input int adx, input int ady, input int bdx, input int bdy,
                            input int buttons);
    poll_t p;
    p.first_dx  = MW'(adx);
    p.first_dy  = MW'(ady);
    p.second_dx = MW'(bdx);
    p.second_dy = MW'(bdy);
    p.buttons   = BUTTON_WIDTH'(buttons);
    poll_queue.push_back(p);
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] report %0d: %s", $realtime, reports_seen, what);
    error_count++;
  endtask

  task automatic write_register(input logic [CFG_INDEX_WIDTH-1:0] index,
                                input logic [CFG_DATA_WIDTH-1:0] data);
    @(posedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= index;
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (index)
      REG_INVERT_FIRST:  cfg_invert_first = data[0];
      REG_INVERT_SECOND: cfg_invert_second = data[0];
      REG_SCROLL_TICK:   cfg_scroll_tick = data[TICK_WIDTH-1:0];
      REG_OFF_AXIS_GAIN: cfg_gain = data[GAIN_WIDTH-1:0];
      default: ;
    endcase
  endtask

  // Unused register bits and an unknown index get random data, which must be ignored.
  task automatic apply_settings(input logic inv_first, input logic inv_second,
                                input logic [TICK_WIDTH-1:0] tick,
                                input logic [GAIN_WIDTH-1:0] gain);
    logic [CFG_DATA_WIDTH-1:0]  junk;
    logic [CFG_INDEX_WIDTH-1:0] spare_index;
    junk = CFG_DATA_WIDTH'($urandom());
    spare_index = CFG_INDEX_WIDTH'($urandom_range(int'(REG_INDEX_UNUSED_MIN),
                                                  (1 << CFG_INDEX_WIDTH) - 1));
    write_register(REG_INVERT_FIRST, {junk[15:1], inv_first});
    write_register(REG_INVERT_SECOND, {~junk[14:0], inv_second});
    write_register(REG_SCROLL_TICK, {junk[7:0], tick});
    write_register(REG_OFF_AXIS_GAIN, gain);
    write_register(spare_index, junk);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (poll_queue.size() != 0 || in_ch.valid || pending_reports.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic hold_receiver();
    sink_hold = 1'b1;
    repeat (RECEIVER_HOLD_CYCLES) @(negedge clk_i);
    sink_hold = 1'b0;
  endtask

  task automatic run_random_phase(input int count, input bit receiver_hold,
                                  input bit mid_pause);
    @(negedge clk_i);
    if (receiver_hold) begin
      fork
        hold_receiver();
      join_none
    end
    for (int i = 0; i < count; i++) begin
      if (mid_pause && i == count / 2) begin
        while (poll_queue.size() != 0 || in_ch.valid || pending_reports.size() != 0) begin
          @(negedge clk_i);
        end
      end
      poll_queue.push_back(random_poll());
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    poll_t offered;
    poll_t next_poll;
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        offered.first_dx  = in_ch.first_dx;
        offered.first_dy  = in_ch.first_dy;
        offered.second_dx = in_ch.second_dx;
        offered.second_dy = in_ch.second_dy;
        offered.buttons   = in_ch.buttons_pressed;
        pending_reports.push_back(fuse_motion(offered));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (poll_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_poll = poll_queue.pop_front();
          in_ch.valid           <= 1'b1;
          in_ch.first_dx        <= next_poll.first_dx;
          in_ch.first_dy        <= next_poll.first_dy;
          in_ch.second_dx       <= next_poll.second_dx;
          in_ch.second_dy       <= next_poll.second_dy;
          in_ch.buttons_pressed <= next_poll.buttons;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    fused_report_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        reports_seen++;
        if (pending_reports.size() == 0) begin
          report_mismatch("report transaction with no poll outstanding");
        end else begin
          want = pending_reports.pop_front();
          if (out_ch.report_valid !== want.report_valid)
            report_mismatch($sformatf("report_valid got %b expected %b",
                                      out_ch.report_valid, want.report_valid));
          if (out_ch.wake_request !== want.wake_request)
            report_mismatch($sformatf("wake_request got %b expected %b",
                                      out_ch.wake_request, want.wake_request));
          if (out_ch.button_mask !== want.button_mask)
            report_mismatch($sformatf("button_mask got %b expected %b",
                                      out_ch.button_mask, want.button_mask));
          if (out_ch.move_x !== want.move_x)
            report_mismatch($sformatf("move_x got %0d expected %0d",
                                      out_ch.move_x, want.move_x));
          if (out_ch.move_y !== want.move_y)
            report_mismatch($sformatf("move_y got %0d expected %0d",
                                      out_ch.move_y, want.move_y));
          if (out_ch.wheel !== want.wheel)
            report_mismatch($sformatf("wheel got %0d expected %0d",
                                      out_ch.wheel, want.wheel));
          if (out_ch.click !== want.click)
            report_mismatch($sformatf("click got %b expected %b",
                                      out_ch.click, want.click));
        end
      end
      out_ch.ready <= !sink_hold && ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_ch.valid           = 1'b0;
    in_ch.first_dx        = '0;
    in_ch.first_dy        = '0;
    in_ch.second_dx       = '0;
    in_ch.second_dy       = '0;
    in_ch.buttons_pressed = '0;
    out_ch.ready          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = '0;
    cfg_ch.data           = '0;
    rst_ni                = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    queue_poll(0, 0, 0, 0, 0);
    queue_poll(0, 0, 0, 0, 7);
    queue_poll(0, 0, 0, 0, 7);
    queue_poll(32767, 32767, 32767, 32767, 7);
    queue_poll(-32768, -32768, -32768, -32768, 1);
    queue_poll(32767, 0, -32768, 0, 1);
    queue_poll(0, 100, 0, 100, 1);
    queue_poll(0, 1, 0, 0, 1);
    queue_poll(0, 1, 0, 0, 1);
    queue_poll(0, -32768, 0, -32768, 2);
    queue_poll(0, 32767, 0, 32767, 4);
    queue_poll(1, 0, 0, 0, 4);
    queue_poll(200, 0, 0, 0, 0);
    queue_poll(0, 0, 1, 0, 0);
    queue_poll(0, 0, -1, 0, 0);
    wait_drained();

    apply_settings(1'b1, 1'b1, 8'd0, 16'hFFFF);
    @(negedge clk_i);
    queue_poll(-32768, -32768, -32768, -32768, 3);
    queue_poll(0, -32768, 0, 0, 3);
    queue_poll(0, 3, 0, -4, 3);
    queue_poll(0, 3, 0, -4, 3);
    queue_poll(0, 0, 1, 0, 5);
    queue_poll(5, 0, 0, 0, 5);
    queue_poll(0, 0, 0, 0, 0);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      case (phase % 4)
        0: begin
          sender_idle_pct = 0;
          sink_stall_pct  = 0;
        end
        1: begin
          sender_idle_pct = 81;
          sink_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          sink_stall_pct  = 81;
        end
        default: begin
          sender_idle_pct = 19;
          sink_stall_pct  = 19;
        end
      endcase
      case (phase % 5)
        0: apply_settings(1'b0, 1'b0, SCROLL_TICK_RESET, GAIN_RESET);
        1: apply_settings(1'b1, 1'b0, 8'd1, 16'hFFFF);
        2: apply_settings(1'b0, 1'b1, 8'hFF, 16'd0);
        3: apply_settings(1'b1, 1'b1, 8'd0, 16'd16384);
        default: apply_settings(($urandom_range(1) != 0), ($urandom_range(1) != 0),
                                TICK_WIDTH'($urandom_range(2, 254)),
                                GAIN_WIDTH'($urandom()));
      endcase
      run_random_phase(POLLS_PER_PHASE, phase == 0, phase == 3);
    end
    wait_drained();

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/dsbmf_pkg.sv
rtl/dsbmf_if.sv
rtl/dsbmf_ctrl.sv
rtl/dsbmf_datapath.sv
rtl/dual_sensor_ball_motion_fuser_core.sv
tb/dual_sensor_ball_motion_fuser_core_tb.sv
